[hw/rtl/three_level_priority_queue_macros.svh]
// Assertion macros used by the priority queue control block.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_MACROS_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TLPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TLPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tlpq_pkg.sv]
// Package: constants, types and helpers of the three-class priority queue.
`default_nettype none

package tlpq_pkg;

   localparam int DEPTH     = 16;
   localparam int NCLASS    = 3;
   localparam int VAL_W     = 32;
   localparam int MODE_W    = 2;
   localparam int CLS_W     = 2;
   localparam int ERR_W     = 2;
   localparam int COUNT_FIELD_W = 5;
   localparam int TOTAL_FIELD_W = 6;

   localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int TOT_W     = $clog2(NCLASS * DEPTH + 1);
   localparam int MEM_DEPTH = NCLASS * DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH  = 2'd0,
      MODE_POP   = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE  = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } err_type;

   localparam logic [CLS_W-1:0] CLS_HIGH = 2'd0;
   localparam logic [CLS_W-1:0] CLS_LOW  = 2'd2;

   typedef struct packed {
      logic              take;  // request transaction accepted
      logic              adv;   // input register moves into result register
   } pipe_ctl_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [VAL_W-1:0]  wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } store_req_type;

   typedef struct packed {
      logic [CLS_W-1:0]                  front_class;
      logic [NCLASS-1:0][CNT_W-1:0]      counts;
      logic [TOT_W-1:0]                  total;
      logic                              empty;
      err_type                           err;
   } res_type;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] cls,
                                                  input logic [PTR_W-1:0] ptr);
      return ADDR_W'(cls) * ADDR_W'(DEPTH) + ADDR_W'(ptr);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/tlpq_if.sv]
// Channel interfaces: request and response of the priority queue.
`default_nettype none

interface tlpq_req_if import tlpq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [VAL_W-1:0]  value;
   logic [CLS_W-1:0]         priority_req;

   modport source (output valid, mode, value, priority_req, input ready);
   modport sink   (input valid, mode, value, priority_req, output ready);
endinterface

interface tlpq_rsp_if import tlpq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VAL_W-1:0]   front_value;
   logic [CLS_W-1:0]          front_class;
   logic [COUNT_FIELD_W-1:0]  count_high;
   logic [COUNT_FIELD_W-1:0]  count_medium;
   logic [COUNT_FIELD_W-1:0]  count_low;
   logic [TOTAL_FIELD_W-1:0]  total_count;
   logic                      is_empty;
   logic [ERR_W-1:0]          error_code;

   modport source (output valid, front_value, front_class, count_high, count_medium,
                   count_low, total_count, is_empty, error_code, input ready);
   modport sink   (input valid, front_value, front_class, count_high, count_medium,
                   count_low, total_count, is_empty, error_code, output ready);
endinterface

`default_nettype wire

[hw/rtl/tlpq_store.sv]
// Value store: one memory holding the three class FIFOs, registered read.
`default_nettype none

module tlpq_store import tlpq_pkg::*; (
   input  logic              clock,
   input  store_req_type     sreq,
   output logic [VAL_W-1:0]  rdata
);

   logic [VAL_W-1:0] mem [MEM_DEPTH];
   logic [VAL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (sreq.we) begin
         mem[sreq.waddr] <= sreq.wdata;
      end
   end

   // same-address write forwards the new value
   always_ff @(posedge clock) begin
      if (sreq.re) begin
         rdata_ff <= (sreq.we && (sreq.waddr == sreq.raddr)) ? sreq.wdata
                                                             : mem[sreq.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hw/rtl/tlpq_ctrl.sv]
// Control: input register, class pointers and counts, next-state and head select.
`default_nettype none
`include "three_level_priority_queue_macros.svh"

module tlpq_ctrl import tlpq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  pipe_ctl_type             ctl,
   input  logic [MODE_W-1:0]        mode,
   input  logic signed [VAL_W-1:0]  value,
   input  logic [CLS_W-1:0]         priority_req,
   output logic                     in_valid,
   output store_req_type            sreq,
   output res_type                  res
);

   logic                          in_valid_ff, in_valid_in;
   logic [MODE_W-1:0]             mode_ff;
   logic [VAL_W-1:0]              value_ff;
   logic [CLS_W-1:0]              cls_ff;

   logic [NCLASS-1:0][PTR_W-1:0]  rp_ff, rp_in;
   logic [NCLASS-1:0][PTR_W-1:0]  wp_ff, wp_in;
   logic [NCLASS-1:0][CNT_W-1:0]  cnt_ff, cnt_in;

   err_type                       err;
   logic                          push_ok;
   logic [ADDR_W-1:0]             waddr;
   logic [ADDR_W-1:0]             raddr;
   logic                          pop_found;
   logic                          head_found;
   logic [CLS_W-1:0]              head_cls;
   logic [TOT_W-1:0]              total;
   logic [NCLASS-1:0]             span_ok;

   // input register, unknown class folds into low
   assign in_valid_in = ctl.take ? 1'b1 : (ctl.adv ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take) begin
         mode_ff  <= mode;
         value_ff <= value;
         cls_ff   <= (priority_req > CLS_LOW) ? CLS_LOW : priority_req;
      end
   end

   always_comb begin
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      cnt_in    = cnt_ff;
      err       = ERR_NONE;
      push_ok   = 1'b0;
      waddr     = '0;
      pop_found = 1'b0;
      case (mode_ff)
         MODE_PUSH: begin
            for (int c = 0; c < NCLASS; c++) begin
               if (CLS_W'(c) == cls_ff) begin
                  if (cnt_ff[c] >= CNT_W'(DEPTH)) begin
                     err = ERR_FULL;
                  end else begin
                     push_ok   = 1'b1;
                     waddr     = slot_addr(CLS_W'(c), wp_ff[c]);
                     wp_in[c]  = next_slot(wp_ff[c]);
                     cnt_in[c] = cnt_ff[c] + 1'b1;
                  end
               end
            end
         end
         MODE_POP: begin
            for (int c = 0; c < NCLASS; c++) begin
               if (!pop_found && (cnt_ff[c] != '0)) begin
                  pop_found = 1'b1;
                  rp_in[c]  = next_slot(rp_ff[c]);
                  cnt_in[c] = cnt_ff[c] - 1'b1;
               end
            end
            if (!pop_found) begin
               err = ERR_EMPTY;
            end
         end
         MODE_CLEAR: begin
            rp_in  = '0;
            wp_in  = '0;
            cnt_in = '0;
         end
         default: begin
         end
      endcase

      // head of the highest non-empty class after the update
      head_found = 1'b0;
      head_cls   = CLS_HIGH;
      raddr      = slot_addr(CLS_HIGH, rp_in[0]);
      total      = '0;
      for (int c = 0; c < NCLASS; c++) begin
         total = total + TOT_W'(cnt_in[c]);
         if (!head_found && (cnt_in[c] != '0)) begin
            head_found = 1'b1;
            head_cls   = CLS_W'(c);
            raddr      = slot_addr(CLS_W'(c), rp_in[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff  <= '0;
         wp_ff  <= '0;
         cnt_ff <= '0;
      end else if (ctl.adv) begin
         rp_ff  <= rp_in;
         wp_ff  <= wp_in;
         cnt_ff <= cnt_in;
      end
   end

   assign in_valid   = in_valid_ff;

   assign sreq.we    = ctl.adv && push_ok;
   assign sreq.waddr = waddr;
   assign sreq.wdata = value_ff;
   assign sreq.re    = ctl.adv;
   assign sreq.raddr = raddr;

   assign res.front_class = head_cls;
   assign res.counts      = cnt_in;
   assign res.total       = total;
   assign res.empty       = !head_found;
   assign res.err         = err;

   // pointer distance must agree with the count (full wraps to zero distance)
   always_comb begin
      for (int c = 0; c < NCLASS; c++) begin
         span_ok[c] = (((wp_ff[c] >= rp_ff[c]) ? CNT_W'(wp_ff[c] - rp_ff[c])
                        : CNT_W'(CNT_W'(wp_ff[c]) + CNT_W'(DEPTH) - CNT_W'(rp_ff[c])))
                       == ((cnt_ff[c] == CNT_W'(DEPTH)) ? '0 : cnt_ff[c]));
      end
   end

   `TLPQ_ASSERT(a_span, clock, reset, &span_ok, "pointer distance disagrees with count")
   `TLPQ_ASSERT_NEXT(a_full_hold, clock, reset, ctl.adv && (err == ERR_FULL), (cnt_ff == $past(cnt_ff)) && (wp_ff == $past(wp_ff)), "push to full class changed state")
   `TLPQ_ASSERT(a_empty_pop, clock, reset, (ctl.adv && (err == ERR_EMPTY)) |-> (cnt_ff == '0), "pop error while items held")
   `TLPQ_ASSERT_NEXT(a_clear, clock, reset, ctl.adv && (mode_ff == MODE_CLEAR), (cnt_ff == '0) && (rp_ff == '0) && (wp_ff == '0), "clear left items behind")

endmodule

`default_nettype wire

[hw/rtl/three_level_priority_queue.sv]
// Top level: three-class strict priority queue with request/response channels.
//
// Usage:
//  - req_chan carries one request per transaction: push (value into class
//    priority_req; class 3 is treated as low), pop (oldest item of the
//    highest non-empty class) or clear. Other mode codes report state only.
//  - rsp_chan returns exactly one transaction per request: new head value
//    and class (zero when empty), per-class counts, total, empty flag and
//    error code (pop while empty, push to full class; both change nothing).
//  - A request passes the input register, then the result register along
//    with the store's registered read; rsp_chan.valid rises once the result
//    register is loaded, which waits while an earlier response is stalled.
//  - Throughput: 1 request per cycle while the receiver takes each response;
//    each request reads one store slot and updates at most one class's
//    pointers and count (clear resets all classes) in a single pass.
//  - Reset clears pointers, counts and both pipeline valid flags at once; the
//    store contents are not cleared, and an unwritten entry is never returned.
//  - When the receiver stalls, the response is held and one more request is
//    taken into the input register; req_chan.ready then drops until the
//    response transaction completes.
`default_nettype none

module three_level_priority_queue import tlpq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tlpq_req_if.sink    req_chan,
   tlpq_rsp_if.source  rsp_chan
);

   pipe_ctl_type      ctl;
   store_req_type     sreq;
   res_type           res;
   res_type           res_ff;
   logic              in_valid;
   logic              out_valid_ff, out_valid_in;
   logic [VAL_W-1:0]  rdata;

   // input register moves on when the result register is free or draining
   assign ctl.adv  = in_valid && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid || ctl.adv;
   assign ctl.take = req_chan.valid && req_chan.ready;

   tlpq_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .mode         (req_chan.mode),
      .value        (req_chan.value),
      .priority_req (req_chan.priority_req),
      .in_valid     (in_valid),
      .sreq         (sreq),
      .res          (res)
   );

   // head value comes out of the store's read register alongside res_ff
   tlpq_store u_store (
      .clock (clock),
      .sreq  (sreq),
      .rdata (rdata)
   );

   assign out_valid_in = ctl.adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         res_ff <= res;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.front_value  = res_ff.empty ? '0 : rdata;
   assign rsp_chan.front_class  = res_ff.front_class;
   assign rsp_chan.count_high   = COUNT_FIELD_W'(res_ff.counts[0]);
   assign rsp_chan.count_medium = COUNT_FIELD_W'(res_ff.counts[1]);
   assign rsp_chan.count_low    = COUNT_FIELD_W'(res_ff.counts[2]);
   assign rsp_chan.total_count  = TOTAL_FIELD_W'(res_ff.total);
   assign rsp_chan.is_empty     = res_ff.empty;
   assign rsp_chan.error_code   = res_ff.err;

endmodule

`default_nettype wire
